// ===== design/assert_macros.svh =====
// assertion macros used by the rng top level
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is held
`define LFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LFR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/lfr_pkg.sv =====
// shared types and constants of the lagged fibonacci rng
// no dependencies
package lfr_pkg;

  localparam int unsigned ValueW  = 15;
  localparam int unsigned ProdW   = 27;
  localparam int unsigned Modulus = 32767;
  localparam int unsigned LcgMul  = 2349;
  localparam int unsigned LcgAdd  = 14867;

  typedef logic [ValueW-1:0] value_t;

  // controller to datapath
  typedef struct packed {
    logic fill_start;
    logic fill_mul;
    logic fill_fold;
    logic draw_commit;
  } lfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_done;
    logic out_free;
  } lfr_status_t;

endpackage

// ===== design/lfr_in_if.sv =====
// draw request channel
// depends on nothing
interface lfr_in_if;
  logic valid;
  logic ready;
  logic draw;
  modport source (output valid, output draw, input ready);
  modport sink (input valid, input draw, output ready);
endinterface

// ===== design/lfr_out_if.sv =====
// random value channel
// depends on lfr_pkg
interface lfr_out_if;
  logic           valid;
  logic           ready;
  lfr_pkg::value_t value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== design/lfr_cfg_if.sv =====
// seed register write channel
// depends on lfr_pkg
interface lfr_cfg_if;
  logic            valid;
  logic            ready;
  lfr_pkg::value_t start_seed;
  modport source (output valid, output start_seed, input ready);
  modport sink (input valid, input start_seed, output ready);
endinterface

// ===== design/lagged_fibonacci_uniform_rng.sv =====
// top level of the additive lagged fibonacci uniform rng
// depends on lfr_pkg, lfr_in_if, lfr_out_if, lfr_cfg_if, lfr_ctrl, lfr_datapath
//
// usage:
//   cfg_i writes the 15-bit start seed; it is always ready and should be written
//   while the block is idle, before the first draw
//   in_i takes one request word; a word with draw clear is consumed and does nothing
//   out_o returns one word per draw: value in units of 1/32767, 0..32767
// draw sequence:
//   a draw runs a read state (ring read into the tap registers), then an add state
//   that adds the taps and registers the sum into out_o; no new request is taken
//   until it commits. the first draw after reset first fills the ring with an lcg
//   (multiply, then fold mod 32767, for each entry) before its own read
// reset:
//   seed clears to zero, ring marked unfilled, slot pointer to zero, taps to offsets;
//   ring contents are not cleared, the fill writes every entry before any read
// stall:
//   a finished word waits in the output register; a new request is still taken,
//   its read and add run, and it holds in the add step until the register frees
module lagged_fibonacci_uniform_rng #(
  parameter int unsigned RING_DEPTH = 55,
  parameter int unsigned NEAR_TAP   = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfr_cfg_if.sink   cfg_i,
  lfr_in_if.sink    in_i,
  lfr_out_if.source out_o
);
  import lfr_pkg::*;

  `include "assert_macros.svh"

  lfr_cmd_t    cmd;
  lfr_status_t status;

  // seed register is a plain flop, never busy
  assign cfg_i.ready = 1'b1;

  // sequencing: idle, fill loop, ring read, add and commit
  lfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_draw_i  (in_i.draw),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ring memory with tap pointers, lcg for the fill, tap adder, output word
  lfr_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .NEAR_TAP   (NEAR_TAP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (cfg_i.valid && cfg_i.ready),
    .seed_i      (cfg_i.start_seed),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.value)
  );

  // at most one datapath operation per cycle
  `LFR_ASSERT(a_cmd_onehot,
    $onehot0({cmd.fill_start, cmd.fill_mul, cmd.fill_fold, cmd.draw_commit}),
    "more than one datapath command")
  // a commit never overwrites a word that is still waiting
  `LFR_ASSERT(a_commit_free, cmd.draw_commit |-> (!out_o.valid || out_o.ready),
    "draw committed over an untaken word")
  // a real draw closes the request side until it finishes
  `LFR_ASSERT(a_busy_after_draw, (in_i.valid && in_i.ready && in_i.draw) |=> !in_i.ready,
    "request taken while a draw is in flight")

endmodule

// ===== design/lfr_ctrl.sv =====
// controller of the rng: fill sequence and draw sequence
// depends on lfr_pkg
module lfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_draw_i,
  output logic                 in_ready_o,
  input  lfr_pkg::lfr_status_t status_i,
  output lfr_pkg::lfr_cmd_t    cmd_o
);
  import lfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_MUL,
    ST_FILL_FOLD,
    ST_READ,
    ST_CALC
  } state_e;

  state_e state_q;
  logic   filled_q;
  logic   take_draw;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take_draw  = in_ready_o && in_valid_i && in_draw_i;

  always_comb begin
    cmd_o             = '0;
    cmd_o.fill_start  = take_draw && !filled_q;
    cmd_o.fill_mul    = (state_q == ST_FILL_MUL);
    cmd_o.fill_fold   = (state_q == ST_FILL_FOLD);
    cmd_o.draw_commit = (state_q == ST_CALC) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      filled_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take_draw) begin
            state_q <= filled_q ? ST_READ : ST_FILL_MUL;
          end
        end
        ST_FILL_MUL: begin
          state_q <= ST_FILL_FOLD;
        end
        ST_FILL_FOLD: begin
          if (status_i.fill_done) begin
            state_q  <= ST_READ;
            filled_q <= 1'b1;
          end else begin
            state_q <= ST_FILL_MUL;
          end
        end
        ST_READ: begin
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/lfr_datapath.sv =====
// datapath of the rng: ring memory, tap pointers, lcg, adder, output register
// depends on lfr_pkg
module lfr_datapath #(
  parameter int unsigned RING_DEPTH = 55,
  parameter int unsigned NEAR_TAP   = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 seed_we_i,
  input  lfr_pkg::value_t      seed_i,
  input  lfr_pkg::lfr_cmd_t    cmd_i,
  output lfr_pkg::lfr_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lfr_pkg::value_t      out_value_o
);
  import lfr_pkg::*;

  localparam int unsigned IdxW    = $clog2(RING_DEPTH);
  localparam int unsigned NearOff = NEAR_TAP % RING_DEPTH;
  localparam int unsigned FarOff  = (RING_DEPTH - NearOff) % RING_DEPTH;
  localparam int unsigned SumW    = ValueW + 1;

  value_t ring_mem [RING_DEPTH];

  logic [IdxW-1:0]  slot_q, near_q, far_q, fill_q;
  value_t           seed_q, lcg_q, rd_near_q, rd_far_q, out_value_q;
  logic [ProdW-1:0] prod_q;
  logic             out_valid_q;

  logic [SumW-1:0]  fold_raw, draw_raw;
  value_t           fold_val, draw_val;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    wrap_inc = (p == IdxW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // mod 2^15-1 by folding the high bits onto the low bits
  assign fold_raw = SumW'(prod_q[ValueW-1:0]) + SumW'(prod_q[ProdW-1:ValueW]);
  assign fold_val = (fold_raw >= SumW'(Modulus)) ? ValueW'(fold_raw - SumW'(Modulus))
                                                 : ValueW'(fold_raw);

  // tap sum, exactly the modulus is kept
  assign draw_raw = SumW'(rd_near_q) + SumW'(rd_far_q);
  assign draw_val = (draw_raw > SumW'(Modulus)) ? ValueW'(draw_raw - SumW'(Modulus))
                                                : ValueW'(draw_raw);

  assign status_o.fill_done = (fill_q == IdxW'(RING_DEPTH - 1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_value_o        = out_value_q;

  // ring memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_fold) begin
      ring_mem[fill_q] <= fold_val;
    end else if (cmd_i.draw_commit) begin
      ring_mem[slot_q] <= draw_val;
    end
    rd_near_q <= ring_mem[near_q];
    rd_far_q  <= ring_mem[far_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_mul) begin
      prod_q <= ProdW'(lcg_q) * ProdW'(LcgMul) + ProdW'(LcgAdd);
    end
    if (cmd_i.draw_commit) begin
      out_value_q <= draw_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      lcg_q       <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      near_q      <= IdxW'(NearOff);
      far_q       <= IdxW'(FarOff);
      out_valid_q <= 1'b0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      if (cmd_i.fill_start) begin
        lcg_q  <= seed_q;
        fill_q <= '0;
      end else if (cmd_i.fill_fold) begin
        lcg_q <= fold_val;
        if (!status_o.fill_done) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.draw_commit) begin
        slot_q      <= wrap_inc(slot_q);
        near_q      <= wrap_inc(near_q);
        far_q       <= wrap_inc(far_q);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// testbench for lagged_fibonacci_uniform_rng: seeded ring fill and additive draws
// checked word by word against an in-bench generator model
// depends on lfr_pkg, lfr_in_if, lfr_out_if, lfr_cfg_if and the rng design files
module testbench;
  import lfr_pkg::*;

  localparam int unsigned RING_DEPTH = 55;
  localparam int unsigned NEAR_TAP   = 24;

  // random draws per phase, three phases
  localparam int unsigned PHASE_DRAWS  = 190;
  // cycles to let pass after the last word before a seed write or the end
  localparam int unsigned SETTLE_CYCLES = 12;
  // long receiver hold-off, started once enough words have come back
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned HOLD_CYCLES = 400;

  localparam value_t SEED_ZERO     = '0;
  localparam value_t SEED_TOP      = value_t'(Modulus - 1);
  localparam value_t SEED_ALL_ONES = '1;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SPARSE
  } rx_mode_e;

  // one row of the opening sequence: draw bit, then idle cycles after it
  typedef struct packed {
    logic       draw;
    logic [3:0] gap;
  } drive_step_t;

  localparam drive_step_t OPENING_STEPS [20] = '{
    '{1'b0, 4'd0},  // clear draw before the fill: ignored, must not start the fill
    '{1'b0, 4'd2},
    '{1'b1, 4'd0},  // first draw, runs the fill from the seed
    '{1'b1, 4'd0},  // back to back behind the fill
    '{1'b1, 4'd0},
    '{1'b0, 4'd0},  // clear draw between two real ones
    '{1'b1, 4'd0},
    '{1'b1, 4'd3},
    '{1'b1, 4'd0},
    '{1'b0, 4'd1},
    '{1'b0, 4'd0},
    '{1'b1, 4'd0},
    '{1'b1, 4'd0},
    '{1'b1, 4'd0},
    '{1'b1, 4'd0},
    '{1'b1, 4'd5},
    '{1'b1, 4'd1},
    '{1'b0, 4'd0},
    '{1'b1, 4'd0},
    '{1'b1, 4'd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lfr_cfg_if seed_bus ();
  lfr_in_if  draw_bus ();
  lfr_out_if value_bus ();

  lagged_fibonacci_uniform_rng #(
    .RING_DEPTH(RING_DEPTH),
    .NEAR_TAP  (NEAR_TAP)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (seed_bus),
    .in_i  (draw_bus),
    .out_o (value_bus)
  );

  always #5 clk_i = ~clk_i;

  // generator model: ring, write slot, fill flag and the seed register
  value_t      ring_copy [RING_DEPTH];
  int unsigned slot_copy;
  bit          ring_filled;
  value_t      seed_reg;

  // words still owed by the block, oldest first
  value_t      pending_values [$];
  int unsigned values_taken;
  int unsigned errors;
  rx_mode_e    rx_mode = RX_OPEN;

  // congruential fill of the whole ring, done on the first real draw
  function automatic void lfg_fill();
    int unsigned s;
    s = 32'(seed_reg);
    for (int unsigned k = 0; k < RING_DEPTH; k++) begin
      s = (s * LcgMul + LcgAdd) % Modulus;
      ring_copy[k] = value_t'(s);
    end
    slot_copy   = 0;
    ring_filled = 1'b1;
  endfunction

  // next value of the generator: add the two taps, fold once, store at the slot
  function automatic value_t lfg_next_value();
    int unsigned off;
    int unsigned near_idx;
    int unsigned far_idx;
    logic [ValueW:0] total;
    if (!ring_filled) lfg_fill();
    off      = NEAR_TAP % RING_DEPTH;
    near_idx = (slot_copy + off) % RING_DEPTH;
    far_idx  = (slot_copy + RING_DEPTH - off) % RING_DEPTH;
    total    = {1'b0, ring_copy[near_idx]} + {1'b0, ring_copy[far_idx]};
    // a sum of exactly the modulus is kept as it is
    if (total > Modulus) total = total - (ValueW + 1)'(Modulus);
    ring_copy[slot_copy] = total[ValueW-1:0];
    slot_copy = (slot_copy + 1) % RING_DEPTH;
    return total[ValueW-1:0];
  endfunction

  // offer one request word and wait for it to be taken
  task automatic offer_word(input logic draw_bit);
    @(negedge clk_i);
    draw_bus.valid <= 1'b1;
    draw_bus.draw  <= draw_bit;
    @(posedge clk_i);
    while (!draw_bus.ready) @(posedge clk_i);
    // only a set draw bit owes a word back
    if (draw_bit) pending_values.push_back(lfg_next_value());
  endtask

  // sender gap with valid held low, payload left as noise
  task automatic idle_sender(input int unsigned n);
    @(negedge clk_i);
    draw_bus.valid <= 1'b0;
    draw_bus.draw  <= 1'($urandom_range(0, 1));
    repeat (n - 1) @(negedge clk_i);
  endtask

  // seed write; once the ring is filled the seed is dead until a reset
  task automatic write_seed(input value_t seed);
    @(negedge clk_i);
    seed_bus.valid      <= 1'b1;
    seed_bus.start_seed <= seed;
    @(posedge clk_i);
    while (!seed_bus.ready) @(posedge clk_i);
    if (!ring_filled) seed_reg = seed;
    @(negedge clk_i);
    seed_bus.valid <= 1'b0;
  endtask

  // wait until every owed word is back, then a few more cycles
  task automatic settle();
    @(negedge clk_i);
    draw_bus.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result check: every returned word against the oldest owed value
  always @(posedge clk_i) begin
    value_t want;
    if (rst_ni && value_bus.valid && value_bus.ready) begin
      values_taken++;
      if (pending_values.size() == 0) begin
        errors++;
        $error("value: expected none, got %0d", value_bus.value);
      end else begin
        want = pending_values.pop_front();
        if (value_bus.value !== want) begin
          errors++;
          $error("value: expected %0d, got %0d", want, value_bus.value);
        end
      end
    end
  end

  // receiver: stall pattern per phase, plus one long hold-off so the block
  // fills its output and add stages and pushes back on the request side
  initial begin
    int unsigned rx_tick;
    int unsigned hold_left;
    bit          hold_done;
    rx_tick   = 0;
    hold_left = 0;
    hold_done = 1'b0;
    value_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_tick++;
      if (hold_left != 0) begin
        hold_left--;
        value_bus.ready <= 1'b0;
      end else if (!hold_done && values_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        value_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: begin
            value_bus.ready <= 1'b1;
          end
          RX_CHOPPY: begin
            value_bus.ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            // short periodic open window, with the odd random opening
            value_bus.ready <= (rx_tick % 7 < 2) || ($urandom_range(0, 5) == 0);
          end
        endcase
      end
    end
  end

  // main sequence
  initial begin
    int unsigned real_draws;
    int unsigned burst;
    logic        draw_bit;
    seed_bus.valid      = 1'b0;
    seed_bus.start_seed = '0;
    draw_bus.valid      = 1'b0;
    draw_bus.draw       = 1'b0;
    values_taken = 0;
    errors       = 0;
    ring_filled  = 1'b0;
    slot_copy    = 0;
    seed_reg     = '0;
    foreach (ring_copy[k]) ring_copy[k] = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // last write before the first draw wins; all-ones seed goes through
    // the congruence like any other value
    write_seed(SEED_ZERO);
    write_seed(SEED_TOP);
    write_seed(SEED_ALL_ONES);

    foreach (OPENING_STEPS[i]) begin
      offer_word(OPENING_STEPS[i].draw);
      if (OPENING_STEPS[i].gap != 0) idle_sender(OPENING_STEPS[i].gap);
    end
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      // seed writes after the fill must leave the sequence alone
      case (phase)
        0: begin
          write_seed(SEED_ZERO);
          rx_mode = RX_CHOPPY;
        end
        1: begin
          write_seed(SEED_TOP);
          rx_mode = RX_OPEN;
        end
        default: begin
          write_seed(value_t'($urandom_range(0, Modulus - 1)));
          rx_mode = RX_SPARSE;
        end
      endcase
      real_draws = 0;
      while (real_draws < PHASE_DRAWS) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          // mostly real draws, the odd clear word mixed in
          draw_bit = ($urandom_range(0, 9) != 0);
          offer_word(draw_bit);
          if (draw_bit) real_draws++;
        end
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      end
      settle();
    end

    if (pending_values.size() != 0) begin
      errors += pending_values.size();
      $error("value: %0d words never returned", pending_values.size());
    end
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
